// ----- src/tun_pkg.sv -----
package tun_pkg;

    // Width of one normal component on the output, signed Q1.15.
    localparam int OUT_BITS = 16;
    // Number of vertex coordinates in one input beat and normal components out.
    localparam int NUM_COORDS = 9;
    localparam int NUM_AXES = 3;

    localparam logic [OUT_BITS-1:0] OUT_POS_MAX = 16'h7FFF;
    localparam logic [OUT_BITS-1:0] OUT_NEG_MAX = 16'h8000;

    typedef logic [OUT_BITS-1:0] t_comp;

endpackage

// ----- src/triangle_unit_normal_unit.sv -----
// Unit face normal of a triangle.
// Slave channel: one beat carries the three vertices A, B, C as nine signed
// coordinates of COORD_BITS each (ax, ay, az, bx, by, bz, cx, cy, cz from bit 0).
// Master channel: one beat carries the normal (nx, ny, nz) in signed Q1.15
// in tdata and the degenerate flag in tuser. A degenerate triangle gives a
// zero normal with tuser high; a component of exactly +1.0 saturates to 32767.
// The pipeline runs through edges, cross product, split squares, sum, one
// stage per bit of the integer square root, one stage per quotient bit of
// the three parallel dividers, and the output register.
// Throughput is one triangle per cycle while the master side is not stalling. Every stage carries its own valid
// bit and holds only while the stage after it is full and stalled, so a
// stall on the master side fills bubbles before it reaches the slave side,
// and nothing is dropped or repeated.
// Reset (i_rst_n low at a clock edge) empties the pipeline; beats in flight
// are discarded and o_s_axis_tready comes back high.
module triangle_unit_normal_unit #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 15
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit, zero padded
    input  logic [((tun_pkg::NUM_COORDS*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // norm_x, norm_y, norm_z from the lowest bit
    output logic [3*tun_pkg::OUT_BITS-1:0] o_m_axis_tdata,
    // degenerate
    output logic o_m_axis_tuser
);
    import tun_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int EW   = CW + 1;
    localparam int PW   = 2 * EW;
    localparam int NW   = PW + 1;
    localparam int MW   = NW;
    localparam int LO   = (MW + 1) / 2;
    localparam int HI   = MW - LO;
    localparam int SW   = 2 * MW + 2;
    localparam int RW   = MW + 1;
    localparam int DW   = RW + 1;
    localparam int QW   = FRAC_BITS + 1;
    localparam int NUMW = RW + QW + 1;
    localparam int QX   = (QW > OUT_BITS) ? QW : OUT_BITS;

    localparam int ST_E = 0;
    localparam int ST_P = 1;
    localparam int ST_N = 2;
    localparam int ST_H = 3;
    localparam int ST_Q = 4;
    localparam int ST_S = 5;
    localparam int ST_D = ST_S + RW + 1;
    localparam int ST_O = ST_D + QW + 1;
    localparam int NS   = ST_O + 1;

    typedef struct packed {
        logic [2:0]          neg;
        logic [2:0][MW-1:0]  mag;
        logic                dg;
    } t_side;

    typedef struct packed {
        logic [2:0] neg;
        logic       dg;
    } t_dside;

    // Valid and ready chain.
    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS:0]   w_rdy;

    assign w_rdy[NS] = i_m_axis_tready;
    assign n_v = {r_v[NS-2:0], i_s_axis_tvalid};

    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++) begin : g_ctl
            assign w_rdy[gi] = !r_v[gi] || w_rdy[gi+1];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[gi] <= 1'b0;
                end else if (w_rdy[gi]) begin
                    r_v[gi] <= n_v[gi];
                end
            end
        end
    endgenerate

    assign o_s_axis_tready = w_rdy[0];

    // Edges.
    logic signed [CW-1:0] w_in [NUM_COORDS];
    logic signed [EW-1:0] r_e [6];

    always_comb begin
        for (int k = 0; k < NUM_COORDS; k++) begin
            w_in[k] = i_s_axis_tdata[k*CW +: CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_E]) begin
            for (int k = 0; k < 3; k++) begin
                r_e[k]   <= EW'(w_in[3+k]) - EW'(w_in[k]);
                r_e[3+k] <= EW'(w_in[6+k]) - EW'(w_in[k]);
            end
        end
    end

    // Cross product terms.
    logic signed [PW-1:0] r_p [6];

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_P]) begin
            r_p[0] <= r_e[1] * r_e[5];
            r_p[1] <= r_e[2] * r_e[4];
            r_p[2] <= r_e[2] * r_e[3];
            r_p[3] <= r_e[0] * r_e[5];
            r_p[4] <= r_e[0] * r_e[4];
            r_p[5] <= r_e[1] * r_e[3];
        end
    end

    logic signed [NW-1:0] r_n [3];

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_N]) begin
            for (int k = 0; k < 3; k++) begin
                r_n[k] <= NW'(r_p[2*k]) - NW'(r_p[2*k+1]);
            end
        end
    end

    // Squares of the magnitudes, split into narrow partial products.
    logic [MW-1:0]      w_mag [3];
    logic [2*HI-1:0]    r_hh [3];
    logic [HI+LO-1:0]   r_hl [3];
    logic [2*LO-1:0]    r_ll [3];
    t_side              r_sd3;
    t_side              r_sd4;
    logic [2*MW-1:0]    r_sq [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = r_n[k][NW-1] ? MW'(-r_n[k]) : MW'(r_n[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_H]) begin
            for (int k = 0; k < 3; k++) begin
                r_hh[k]      <= w_mag[k][MW-1:LO] * w_mag[k][MW-1:LO];
                r_hl[k]      <= w_mag[k][MW-1:LO] * w_mag[k][LO-1:0];
                r_ll[k]      <= w_mag[k][LO-1:0] * w_mag[k][LO-1:0];
                r_sd3.neg[k] <= r_n[k][NW-1];
                r_sd3.mag[k] <= w_mag[k];
            end
            r_sd3.dg <= (r_n[0] == '0) && (r_n[1] == '0) && (r_n[2] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_Q]) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= ((2*MW)'(r_hh[k]) << (2*LO)) + ((2*MW)'(r_hl[k]) << (LO+1))
                         + (2*MW)'(r_ll[k]);
            end
            r_sd4 <= r_sd3;
        end
    end

    // Integer square root, one result bit per stage.
    logic [SW-1:0] r_sq_rem [RW+1];
    logic [RW-1:0] r_sq_res [RW+1];
    t_side         r_sq_sd  [RW+1];

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_S]) begin
            r_sq_rem[0] <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_sq_res[0] <= '0;
            r_sq_sd[0]  <= r_sd4;
        end
    end

    generate
        for (gi = 1; gi <= RW; gi++) begin : g_sqrt
            localparam int B = RW - gi;
            logic [SW-1:0] w_t;
            assign w_t = ({{(SW-RW){1'b0}}, r_sq_res[gi-1]} << (B+1))
                       | ({{(SW-1){1'b0}}, 1'b1} << (2*B));
            always_ff @(posedge i_clk) begin
                if (w_rdy[ST_S+gi]) begin
                    if (w_t <= r_sq_rem[gi-1]) begin
                        r_sq_rem[gi] <= r_sq_rem[gi-1] - w_t;
                        r_sq_res[gi] <= r_sq_res[gi-1] | ({{(RW-1){1'b0}}, 1'b1} << B);
                    end else begin
                        r_sq_rem[gi] <= r_sq_rem[gi-1];
                        r_sq_res[gi] <= r_sq_res[gi-1];
                    end
                    r_sq_sd[gi] <= r_sq_sd[gi-1];
                end
            end
        end
    endgenerate

    // Three dividers in parallel: (mag * 2^(F+1) + L) / (2L), one quotient bit a stage.
    logic [DW-1:0]   r_dv_rem [QW+1][3];
    logic [QW-1:0]   r_dv_low [QW+1][3];
    logic [QW-1:0]   r_dv_q   [QW+1][3];
    logic [DW-1:0]   r_dv_den [QW+1];
    t_dside          r_dv_sd  [QW+1];
    logic [NUMW-1:0] w_num [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_num[k] = (NUMW'(r_sq_sd[RW].mag[k]) << QW) + NUMW'(r_sq_res[RW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_D]) begin
            for (int k = 0; k < 3; k++) begin
                r_dv_rem[0][k] <= w_num[k][NUMW-1:QW];
                r_dv_low[0][k] <= w_num[k][QW-1:0];
                r_dv_q[0][k]   <= '0;
            end
            r_dv_den[0]    <= {r_sq_res[RW], 1'b0};
            r_dv_sd[0].neg <= r_sq_sd[RW].neg;
            r_dv_sd[0].dg  <= r_sq_sd[RW].dg;
        end
    end

    generate
        for (gi = 1; gi <= QW; gi++) begin : g_div
            logic [DW:0] w_t [3];
            always_comb begin
                for (int k = 0; k < 3; k++) begin
                    w_t[k] = {r_dv_rem[gi-1][k], r_dv_low[gi-1][k][QW-1]};
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_rdy[ST_D+gi]) begin
                    for (int k = 0; k < 3; k++) begin
                        if (w_t[k] >= {1'b0, r_dv_den[gi-1]}) begin
                            r_dv_rem[gi][k] <= DW'(w_t[k] - {1'b0, r_dv_den[gi-1]});
                            r_dv_q[gi][k]   <= {r_dv_q[gi-1][k][QW-2:0], 1'b1};
                        end else begin
                            r_dv_rem[gi][k] <= w_t[k][DW-1:0];
                            r_dv_q[gi][k]   <= {r_dv_q[gi-1][k][QW-2:0], 1'b0};
                        end
                        r_dv_low[gi][k] <= r_dv_low[gi-1][k] << 1;
                    end
                    r_dv_den[gi] <= r_dv_den[gi-1];
                    r_dv_sd[gi]  <= r_dv_sd[gi-1];
                end
            end
        end
    endgenerate

    // Sign, saturation and the output register.
    t_comp          w_out [3];
    logic [QX-1:0]  w_qx  [3];
    t_comp          r_out [3];
    logic           r_dg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_qx[k] = QX'(r_dv_q[QW][k]);
            if (r_dv_sd[QW].dg) begin
                w_out[k] = '0;
            end else if (r_dv_sd[QW].neg[k]) begin
                if (w_qx[k] >= QX'(OUT_NEG_MAX)) begin
                    w_out[k] = OUT_NEG_MAX;
                end else begin
                    w_out[k] = OUT_BITS'(-w_qx[k]);
                end
            end else begin
                if (w_qx[k] > QX'(OUT_POS_MAX)) begin
                    w_out[k] = OUT_POS_MAX;
                end else begin
                    w_out[k] = OUT_BITS'(w_qx[k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_O]) begin
            for (int k = 0; k < 3; k++) begin
                r_out[k] <= w_out[k];
            end
            r_dg <= r_dv_sd[QW].dg;
        end
    end

    assign o_m_axis_tvalid = r_v[ST_O];
    assign o_m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign o_m_axis_tuser  = r_dg;

`ifndef ASSERT_OFF
    // The root leaves a remainder of at most 2L, so L is the floor of the root.
    a_sqrt_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[ST_S+RW] |-> (r_sq_rem[RW] <= SW'({r_sq_res[RW], 1'b0})))
        else $error("square root remainder out of range");

    // Every divider ends with a remainder below the divisor unless the triangle is degenerate.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[ST_D+QW] && !r_dv_sd[QW].dg) |->
        ((r_dv_rem[QW][0] < r_dv_den[QW]) && (r_dv_rem[QW][1] < r_dv_den[QW])
         && (r_dv_rem[QW][2] < r_dv_den[QW])))
        else $error("divider remainder not below divisor");

    // A degenerate triangle leaves with an all-zero normal.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("degenerate beat with nonzero normal");
`endif

endmodule
